// File: src/sfd_pkg.sv
package sfd_pkg;

  localparam logic [7:0] START_BYTE = 8'hFF;
  localparam logic [7:0] CENTI      = 8'd100;
  localparam logic [7:0] SIGN_NEG   = 8'd1;

  // frame byte positions; POS_IDLE waits for a start byte
  localparam logic [3:0] POS_IDLE    = 4'd0;
  localparam logic [3:0] POS_CONC_HI = 4'd4;
  localparam logic [3:0] POS_CONC_LO = 4'd5;
  localparam logic [3:0] POS_SIGN    = 4'd8;
  localparam logic [3:0] POS_T_WHOLE = 4'd9;
  localparam logic [3:0] POS_T_FRAC  = 4'd10;
  localparam logic [3:0] POS_H_WHOLE = 4'd11;
  localparam logic [3:0] POS_H_FRAC  = 4'd12;
  localparam logic [3:0] POS_CHECK   = 4'd13;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int unsigned OUT_DATA_W = 48;

  // one finished frame, as handed from front to back
  typedef struct packed {
    logic        ok;
    logic [15:0] conc;
    logic        temp_neg;
    logic [7:0]  temp_whole;
    logic [7:0]  temp_frac;
    logic [7:0]  hum_whole;
    logic [7:0]  hum_frac;
  } frame_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// File: src/sfd_front.sv
module sfd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  sfd_pkg::queue_stat_t q_stat,
  output logic                push,
  output sfd_pkg::frame_rec_t push_rec
);
  import sfd_pkg::*;

  logic [3:0] pos_r, pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] conc_hi_r, conc_lo_r, t_whole_r, t_frac_r, h_whole_r, h_frac_r;
  logic       t_neg_r;
  logic       accept;
  logic       in_frame;
  logic [7:0] expect_sum;

  assign in_tready  = !q_stat.full;
  assign accept     = in_tvalid && in_tready;
  assign in_frame   = (pos_r != POS_IDLE) && (pos_r <= POS_CHECK);
  assign expect_sum = 8'(8'd0 - sum_r);

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    push    = 1'b0;
    if (accept) begin
      priority if (!in_frame) begin
        sum_nxt = 8'd0;
        pos_nxt = (in_tdata == START_BYTE) ? 4'd1 : POS_IDLE;
      end else if (pos_r == POS_CHECK) begin
        push    = 1'b1;
        pos_nxt = POS_IDLE;
        sum_nxt = 8'd0;
      end else begin
        sum_nxt = 8'(sum_r + in_tdata);
        pos_nxt = 4'(pos_r + 4'd1);
      end
    end
  end

  assign push_rec.ok         = (expect_sum == in_tdata);
  assign push_rec.conc       = {conc_hi_r, conc_lo_r};
  assign push_rec.temp_neg   = t_neg_r;
  assign push_rec.temp_whole = t_whole_r;
  assign push_rec.temp_frac  = t_frac_r;
  assign push_rec.hum_whole  = h_whole_r;
  assign push_rec.hum_frac   = h_frac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= POS_IDLE;
      sum_r     <= 8'd0;
      conc_hi_r <= 8'd0;
      conc_lo_r <= 8'd0;
      t_neg_r   <= 1'b0;
      t_whole_r <= 8'd0;
      t_frac_r  <= 8'd0;
      h_whole_r <= 8'd0;
      h_frac_r  <= 8'd0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
      if (accept && in_frame) begin
        unique case (pos_r)
          POS_CONC_HI: conc_hi_r <= in_tdata;
          POS_CONC_LO: conc_lo_r <= in_tdata;
          POS_SIGN:    t_neg_r   <= (in_tdata == SIGN_NEG);
          POS_T_WHOLE: t_whole_r <= in_tdata;
          POS_T_FRAC:  t_frac_r  <= in_tdata;
          POS_H_WHOLE: h_whole_r <= in_tdata;
          POS_H_FRAC:  h_frac_r  <= in_tdata;
          default: ;
        endcase
      end
    end
  end

endmodule

// File: src/sfd_queue.sv
module sfd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sfd_pkg::frame_rec_t  push_rec,
  input  logic                 pop,
  output sfd_pkg::frame_rec_t  head_rec,
  output sfd_pkg::queue_stat_t q_stat
);
  import sfd_pkg::*;

  frame_rec_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_push, do_pop;

  assign q_stat.full  = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_rec     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= QPTR_W'(wr_ptr_r + 1'b1);
      if (do_pop)  rd_ptr_r <= QPTR_W'(rd_ptr_r + 1'b1);
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= (QPTR_W+1)'(cnt_r + 1'b1);
        2'b01:   cnt_r <= (QPTR_W+1)'(cnt_r - 1'b1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: src/sfd_back.sv
module sfd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sfd_pkg::frame_rec_t  head_rec,
  input  sfd_pkg::queue_stat_t q_stat,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [sfd_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                 out_tuser
);
  import sfd_pkg::*;

  logic        valid_r;
  logic [15:0] conc_r, temp_r;
  logic [14:0] hum_r;
  logic        ok_r;
  logic        load;
  logic [14:0] t_mag, h_val;
  logic [15:0] temp_val;

  assign load = !q_stat.empty && (!valid_r || out_tready);
  assign pop  = load;

  // whole * 100 + fraction; fraction above 99 is added as is
  assign t_mag    = 15'(head_rec.temp_whole) * 15'(CENTI) + 15'(head_rec.temp_frac);
  assign h_val    = 15'(head_rec.hum_whole) * 15'(CENTI) + 15'(head_rec.hum_frac);
  assign temp_val = head_rec.temp_neg ? 16'(16'd0 - {1'b0, t_mag}) : {1'b0, t_mag};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  // bad frames report zero values
  always_ff @(posedge clk) begin
    if (load) begin
      ok_r   <= head_rec.ok;
      conc_r <= head_rec.ok ? head_rec.conc : 16'd0;
      temp_r <= head_rec.ok ? temp_val : 16'd0;
      hum_r  <= head_rec.ok ? h_val : 15'd0;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = ok_r;
  assign out_tdata  = {1'b0, hum_r, temp_r, conc_r};

endmodule

// File: src/sensor_frame_deframer.sv
// Sensor frame deframer: takes one received serial byte per word and
// accepts a word on every clock unless the queue is full. Bytes are dropped
// until a 0xFF start byte, then a 14-byte frame is collected; its last byte
// yields one result word, through the queue into the output register. A
// short queue of four finished frames sits between the byte framer and the
// output stage, so input stalls only when that queue is full because the
// output side is held off. out_tuser is the checksum-good flag; for a bad
// frame the value fields read zero. Temperature is signed hundredths,
// negated when the sign byte is 1; humidity is unsigned hundredths.
module sensor_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] formaldehyde_ppb, [31:16] temperature_centi,
                                  // [46:32] humidity_centi, [47] zero
  output logic        out_tuser   // [0] checksum_ok
);
  import sfd_pkg::*;

  queue_stat_t q_stat;
  frame_rec_t  push_rec, head_rec;
  logic        push, pop;

  sfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_rec  (push_rec)
  );

  sfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .q_stat   (q_stat)
  );

  sfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_rec   (head_rec),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: src/sfd_checker.sv
module sfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tuser
);

  // a result is always flushed by reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result word changed");

  // corrupted frames carry zero values
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 48'd0)
    else $error("bad frame has nonzero values");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:32] <= 16'd25755)
    else $error("humidity out of range");

  // input stalls only while a result is waiting at the output
  a_input_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

endmodule

bind sensor_frame_deframer sfd_checker u_sfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
